// ===== design/bole_pkg.sv =====
// ----------------------------------------------------------------------------
// bole_pkg: shared definitions for the bounded ordered list engine
// Command and status codes, controller command fields and the datapath
// status bundle that passes between the controller and the datapath.
// ----------------------------------------------------------------------------
package bole_pkg;

  localparam int DEPTH_DEF        = 16;
  localparam int PAYLOAD_BITS_DEF = 32;

  // command codes
  localparam logic [2:0] CMD_APPEND = 3'd0;
  localparam logic [2:0] CMD_INSERT = 3'd1;
  localparam logic [2:0] CMD_HEAD   = 3'd2;
  localparam logic [2:0] CMD_REMOVE = 3'd3;
  localparam logic [2:0] CMD_FIND   = 3'd4;
  localparam logic [2:0] CMD_UPDATE = 3'd5;
  localparam logic [2:0] CMD_CLEAR  = 3'd6;

  // result status codes
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_FULL   = 2'd1;
  localparam logic [1:0] STAT_BADPOS = 2'd2;
  localparam logic [1:0] STAT_NOKEY  = 2'd3;

  // pointer operations
  localparam logic [2:0] PTR_HOLD = 3'd0;
  localparam logic [2:0] PTR_TOP  = 3'd1;
  localparam logic [2:0] PTR_ZERO = 3'd2;
  localparam logic [2:0] PTR_INC  = 3'd3;
  localparam logic [2:0] PTR_DEC  = 3'd4;
  localparam logic [2:0] PTR_HIT  = 3'd5;

  // memory write operations
  localparam logic [2:0] WR_NONE = 3'd0;
  localparam logic [2:0] WR_UP   = 3'd1;
  localparam logic [2:0] WR_DOWN = 3'd2;
  localparam logic [2:0] WR_NEW  = 3'd3;
  localparam logic [2:0] WR_UPD  = 3'd4;

  // entry count operations
  localparam logic [1:0] CNT_HOLD = 2'd0;
  localparam logic [1:0] CNT_INC  = 2'd1;
  localparam logic [1:0] CNT_DEC  = 2'd2;
  localparam logic [1:0] CNT_CLR  = 2'd3;

  // result index and payload sources
  localparam logic [2:0] SRC_NONE = 3'd0;
  localparam logic [2:0] SRC_POS  = 3'd1;
  localparam logic [2:0] SRC_CMP  = 3'd2;
  localparam logic [2:0] SRC_HIT  = 3'd3;
  localparam logic [2:0] SRC_FIND = 3'd4;

  typedef struct packed {
    logic       load;
    logic       rd_en;
    logic [2:0] ptr_op;
    logic [2:0] wr_op;
    logic [1:0] cnt_op;
    logic       res_set;
    logic [1:0] res_status;
    logic [2:0] res_src;
  } ctrl_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       full;
    logic       badpos;
    logic       pos_at_end;
    logic       empty;
    logic       ptr_at_pos;
    logic       ptr_last;
    logic       ptr_lt_cnt;
    logic       match;
    logic       cmp_last;
  } sts_t;

endpackage

// ===== design/bole_ctrl.sv =====
// ----------------------------------------------------------------------------
// bole_ctrl: command sequencer
// Decodes each command and steps the datapath through search, shift and
// write phases, then loads the result.
// ----------------------------------------------------------------------------
module bole_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  bole_pkg::sts_t  sts,
  output bole_pkg::ctrl_t ctrl
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DECODE   = 3'd1;
  localparam logic [2:0] S_SHIFT_UP = 3'd2;
  localparam logic [2:0] S_UP_DRAIN = 3'd3;
  localparam logic [2:0] S_PLACE    = 3'd4;
  localparam logic [2:0] S_SEARCH   = 3'd5;
  localparam logic [2:0] S_SHIFT_DN = 3'd6;
  localparam logic [2:0] S_DN_DRAIN = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          ctrl.load = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.cmd)
          bole_pkg::CMD_APPEND, bole_pkg::CMD_INSERT, bole_pkg::CMD_HEAD: begin
            if (sts.full) begin
              ctrl.res_set    = 1'b1;
              ctrl.res_status = bole_pkg::STAT_FULL;
              state_nxt       = S_IDLE;
            end else if (sts.badpos) begin
              ctrl.res_set    = 1'b1;
              ctrl.res_status = bole_pkg::STAT_BADPOS;
              state_nxt       = S_IDLE;
            end else if (sts.pos_at_end) begin
              state_nxt = S_PLACE;
            end else begin
              ctrl.ptr_op = bole_pkg::PTR_TOP;
              state_nxt   = S_SHIFT_UP;
            end
          end
          bole_pkg::CMD_REMOVE, bole_pkg::CMD_FIND, bole_pkg::CMD_UPDATE: begin
            if (sts.empty) begin
              ctrl.res_set    = 1'b1;
              ctrl.res_status = bole_pkg::STAT_NOKEY;
              state_nxt       = S_IDLE;
            end else begin
              ctrl.ptr_op = bole_pkg::PTR_ZERO;
              state_nxt   = S_SEARCH;
            end
          end
          bole_pkg::CMD_CLEAR: begin
            ctrl.cnt_op  = bole_pkg::CNT_CLR;
            ctrl.res_set = 1'b1;
            state_nxt    = S_IDLE;
          end
          default: begin
            ctrl.res_set = 1'b1;
            state_nxt    = S_IDLE;
          end
        endcase
      end
      S_SHIFT_UP: begin
        // read descending, each registered copy is written one slot up
        ctrl.rd_en  = 1'b1;
        ctrl.ptr_op = bole_pkg::PTR_DEC;
        ctrl.wr_op  = bole_pkg::WR_UP;
        if (sts.ptr_at_pos) begin
          state_nxt = S_UP_DRAIN;
        end
      end
      S_UP_DRAIN: begin
        ctrl.wr_op = bole_pkg::WR_UP;
        state_nxt  = S_PLACE;
      end
      S_PLACE: begin
        ctrl.wr_op   = bole_pkg::WR_NEW;
        ctrl.cnt_op  = bole_pkg::CNT_INC;
        ctrl.res_set = 1'b1;
        ctrl.res_src = bole_pkg::SRC_POS;
        state_nxt    = S_IDLE;
      end
      S_SEARCH: begin
        if (sts.match) begin
          ctrl.res_set = 1'b1;
          state_nxt    = S_IDLE;
          case (sts.cmd)
            bole_pkg::CMD_FIND: begin
              ctrl.res_src = bole_pkg::SRC_FIND;
            end
            bole_pkg::CMD_UPDATE: begin
              ctrl.wr_op   = bole_pkg::WR_UPD;
              ctrl.res_src = bole_pkg::SRC_CMP;
            end
            default: begin
              if (sts.cmp_last) begin
                ctrl.cnt_op  = bole_pkg::CNT_DEC;
                ctrl.res_src = bole_pkg::SRC_CMP;
              end else begin
                // hold the result until the tail has moved down
                ctrl.res_set = 1'b0;
                ctrl.ptr_op  = bole_pkg::PTR_HIT;
                state_nxt    = S_SHIFT_DN;
              end
            end
          endcase
        end else if (sts.cmp_last) begin
          ctrl.res_set    = 1'b1;
          ctrl.res_status = bole_pkg::STAT_NOKEY;
          state_nxt       = S_IDLE;
        end else if (sts.ptr_lt_cnt) begin
          ctrl.rd_en  = 1'b1;
          ctrl.ptr_op = bole_pkg::PTR_INC;
        end
      end
      S_SHIFT_DN: begin
        ctrl.rd_en  = 1'b1;
        ctrl.ptr_op = bole_pkg::PTR_INC;
        ctrl.wr_op  = bole_pkg::WR_DOWN;
        if (sts.ptr_last) begin
          state_nxt = S_DN_DRAIN;
        end
      end
      S_DN_DRAIN: begin
        ctrl.wr_op   = bole_pkg::WR_DOWN;
        ctrl.cnt_op  = bole_pkg::CNT_DEC;
        ctrl.res_set = 1'b1;
        ctrl.res_src = bole_pkg::SRC_HIT;
        state_nxt    = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/bole_dp.sv =====
// ----------------------------------------------------------------------------
// bole_dp: list storage and datapath
// Entry memory with one write and one registered read port, the walk
// pointer, the entry count, the compare stage and the result registers.
// ----------------------------------------------------------------------------
module bole_dp #(
  parameter int DEPTH        = bole_pkg::DEPTH_DEF,
  parameter int PAYLOAD_BITS = bole_pkg::PAYLOAD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  bole_pkg::ctrl_t    ctrl,
  output bole_pkg::sts_t     sts,
  input  logic [2:0]         in_cmd,
  input  logic [4:0]         in_position,
  input  logic signed [31:0] in_key,
  input  logic [31:0]        in_payload,
  output logic               out_strobe,
  output logic [1:0]         out_status,
  output logic [3:0]         out_found_index,
  output logic [31:0]        out_found_payload,
  output logic [4:0]         out_entry_total
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = IDX_W + 1;
  localparam int PW    = (CNT_W > 5) ? CNT_W : 5;

  logic signed [31:0]        mem_key [DEPTH];
  logic [PAYLOAD_BITS-1:0]   mem_pay [DEPTH];

  logic [2:0]                cmd_r;
  logic [PW-1:0]             pos_r;
  logic signed [31:0]        key_r;
  logic [PAYLOAD_BITS-1:0]   pay_r;
  logic [CNT_W-1:0]          count_r;
  logic [CNT_W-1:0]          count_nxt;
  logic [CNT_W-1:0]          ptr_r;
  logic [CNT_W-1:0]          ptr_nxt;
  logic                      vld_r;
  logic [IDX_W-1:0]          cmp_idx_r;
  logic [IDX_W-1:0]          hit_r;
  logic signed [31:0]        rd_key_r;
  logic [PAYLOAD_BITS-1:0]   rd_pay_r;

  logic                      wr_en;
  logic [IDX_W-1:0]          wr_addr;
  logic signed [31:0]        wr_key;
  logic [PAYLOAD_BITS-1:0]   wr_pay;
  logic [PW-1:0]             pos_load;

  logic                      out_strobe_r;
  logic [1:0]                out_status_r;
  logic [3:0]                out_found_index_r;
  logic [31:0]               out_found_payload_r;
  logic [4:0]                out_entry_total_r;

  // ---- input latch ----
  always_comb begin
    case (in_cmd)
      bole_pkg::CMD_APPEND: pos_load = PW'(count_r);
      bole_pkg::CMD_HEAD:   pos_load = '0;
      default:              pos_load = PW'(in_position);
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r <= in_cmd;
      pos_r <= pos_load;
      key_r <= in_key;
      pay_r <= PAYLOAD_BITS'(in_payload);
    end
  end

  // ---- count and pointer ----
  always_comb begin
    case (ctrl.cnt_op)
      bole_pkg::CNT_INC: count_nxt = count_r + 1'b1;
      bole_pkg::CNT_DEC: count_nxt = count_r - 1'b1;
      bole_pkg::CNT_CLR: count_nxt = '0;
      default:           count_nxt = count_r;
    endcase
  end

  always_comb begin
    case (ctrl.ptr_op)
      bole_pkg::PTR_TOP:  ptr_nxt = count_r - 1'b1;
      bole_pkg::PTR_ZERO: ptr_nxt = '0;
      bole_pkg::PTR_INC:  ptr_nxt = ptr_r + 1'b1;
      bole_pkg::PTR_DEC:  ptr_nxt = ptr_r - 1'b1;
      bole_pkg::PTR_HIT:  ptr_nxt = CNT_W'(cmp_idx_r) + 1'b1;
      default:            ptr_nxt = ptr_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      vld_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      vld_r   <= ctrl.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    if (ctrl.rd_en) begin
      cmp_idx_r <= ptr_r[IDX_W-1:0];
    end
    if (ctrl.ptr_op == bole_pkg::PTR_HIT) begin
      hit_r <= cmp_idx_r;
    end
  end

  // ---- entry memory ----
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cmp_idx_r;
    wr_key  = rd_key_r;
    wr_pay  = rd_pay_r;
    case (ctrl.wr_op)
      bole_pkg::WR_UP: begin
        wr_en   = vld_r;
        wr_addr = IDX_W'(cmp_idx_r + 1'b1);
      end
      bole_pkg::WR_DOWN: begin
        wr_en   = vld_r;
        wr_addr = IDX_W'(cmp_idx_r - 1'b1);
      end
      bole_pkg::WR_NEW: begin
        wr_en   = 1'b1;
        wr_addr = pos_r[IDX_W-1:0];
        wr_key  = key_r;
        wr_pay  = pay_r;
      end
      bole_pkg::WR_UPD: begin
        // the stored key equals key_r on a hit, so rewrite both
        wr_en  = 1'b1;
        wr_key = key_r;
        wr_pay = pay_r;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_key[wr_addr] <= wr_key;
      mem_pay[wr_addr] <= wr_pay;
    end
    if (ctrl.rd_en) begin
      rd_key_r <= mem_key[ptr_r[IDX_W-1:0]];
      rd_pay_r <= mem_pay[ptr_r[IDX_W-1:0]];
    end
  end

  // ---- status to the controller ----
  always_comb begin
    sts.cmd        = cmd_r;
    sts.full       = (count_r == CNT_W'(DEPTH));
    sts.badpos     = (cmd_r == bole_pkg::CMD_INSERT) && (pos_r > PW'(count_r));
    sts.pos_at_end = (pos_r == PW'(count_r));
    sts.empty      = (count_r == '0);
    sts.ptr_at_pos = (PW'(ptr_r) == pos_r);
    sts.ptr_last   = ((ptr_r + 1'b1) == count_r);
    sts.ptr_lt_cnt = (ptr_r < count_r);
    sts.match      = vld_r && (rd_key_r == key_r);
    sts.cmp_last   = vld_r && ((CNT_W'(cmp_idx_r) + 1'b1) == count_r);
  end

  // ---- result registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= ctrl.res_set;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.res_set) begin
      out_status_r      <= ctrl.res_status;
      out_entry_total_r <= 5'(count_nxt);
      case (ctrl.res_src)
        bole_pkg::SRC_POS: begin
          out_found_index_r   <= 4'(pos_r);
          out_found_payload_r <= '0;
        end
        bole_pkg::SRC_CMP: begin
          out_found_index_r   <= 4'(cmp_idx_r);
          out_found_payload_r <= '0;
        end
        bole_pkg::SRC_HIT: begin
          out_found_index_r   <= 4'(hit_r);
          out_found_payload_r <= '0;
        end
        bole_pkg::SRC_FIND: begin
          out_found_index_r   <= 4'(cmp_idx_r);
          out_found_payload_r <= 32'(rd_pay_r);
        end
        default: begin
          out_found_index_r   <= '0;
          out_found_payload_r <= '0;
        end
      endcase
    end
  end

  assign out_strobe        = out_strobe_r;
  assign out_status        = out_status_r;
  assign out_found_index   = out_found_index_r;
  assign out_found_payload = out_found_payload_r;
  assign out_entry_total   = out_entry_total_r;

endmodule

// ===== design/bounded_ordered_list_engine.sv =====
// Walk: inserts, removes and key searches step through the entry memory one entry a
//   cycle through its single read port; an append writes at the end without a walk.
// Throughput: one command at a time; a new start is taken in the cycle the result
//   strobe is up. Results cannot be stalled: out_strobe is high for one cycle.
// Reset: synchronous, active low; clears the entry count, no memory sweep.
// ----------------------------------------------------------------------------
// bounded_ordered_list_engine: ordered key/payload list
// Append, insert, insert at head, remove, find, update and clear on a list
// of up to DEPTH entries, one result beat per command.
// ----------------------------------------------------------------------------
module bounded_ordered_list_engine #(
  parameter int DEPTH        = bole_pkg::DEPTH_DEF,
  parameter int PAYLOAD_BITS = bole_pkg::PAYLOAD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_cmd,
  input  logic [4:0]         in_position,
  input  logic signed [31:0] in_key,
  input  logic [31:0]        in_payload,
  output logic               out_strobe,
  output logic [1:0]         out_status,
  output logic [3:0]         out_found_index,
  output logic [31:0]        out_found_payload,
  output logic [4:0]         out_entry_total
);

  bole_pkg::ctrl_t ctrl;
  bole_pkg::sts_t  sts;

  bole_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .ctrl  (ctrl)
  );

  bole_dp #(
    .DEPTH        (DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctrl              (ctrl),
    .sts               (sts),
    .in_cmd            (in_cmd),
    .in_position       (in_position),
    .in_key            (in_key),
    .in_payload        (in_payload),
    .out_strobe        (out_strobe),
    .out_status        (out_status),
    .out_found_index   (out_found_index),
    .out_found_payload (out_found_payload),
    .out_entry_total   (out_entry_total)
  );

  // a result beat only follows a busy cycle
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result beat without a command in flight");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_status != bole_pkg::STAT_OK)) |->
      ((out_found_index == '0) && (out_found_payload == '0)))
    else $error("failed command reported nonzero index or payload");

  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.res_set |-> busy)
    else $error("result loaded while idle");

endmodule
